// ----- design/dvrt_pkg.sv -----
// ----------------------------------------------------------------------------
// dvrt_pkg
// Shared types and constants of the distance-vector route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int OP_W   = 2;
  localparam int NODE_W = 4;
  localparam int COST_W = 8;

  localparam logic [COST_W-1:0] COST_MAX = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_RECEIVE   = 2'd0,
    OP_ADVERTISE = 2'd1,
    OP_CLEAR     = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RECV,
    ST_SCAN,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;       // latch request, read entry of its destination
    logic clear_valid;  // empty the table
    logic init_wr;      // install own entry
    logic recv_eval;    // apply route update
    logic idx_clear;
    logic idx_inc;
    logic scan_rd;      // read entry at scan index
    logic load_out;     // fill output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_valid;
    logic scan_end;
    logic scan_last;
    logic out_free;
  } ctrl_status_t;

endpackage

// ----- design/dvrt_route_if.sv -----
// ----------------------------------------------------------------------------
// dvrt_route_if
// Request channel: one route update, advertisement or clear per request.
// ----------------------------------------------------------------------------
interface dvrt_route_if;
  logic                        valid;
  logic                        ready;
  logic [dvrt_pkg::OP_W-1:0]   operation;
  logic [dvrt_pkg::NODE_W-1:0] route_dest;
  logic [dvrt_pkg::NODE_W-1:0] route_hop;
  logic [dvrt_pkg::COST_W-1:0] route_cost;

  modport source (output valid, output operation, output route_dest, output route_hop,
                  output route_cost, input ready);
  modport sink (input valid, input operation, input route_dest, input route_hop,
                input route_cost, output ready);
endinterface

// ----- design/dvrt_adv_if.sv -----
// ----------------------------------------------------------------------------
// dvrt_adv_if
// Advertisement channel: one advertised table entry per request.
// ----------------------------------------------------------------------------
interface dvrt_adv_if;
  logic                        valid;
  logic                        ready;
  logic [dvrt_pkg::NODE_W-1:0] adv_dest;
  logic [dvrt_pkg::NODE_W-1:0] adv_hop;
  logic [dvrt_pkg::COST_W-1:0] adv_cost;
  logic                        adv_last;

  modport source (output valid, output adv_dest, output adv_hop, output adv_cost,
                  output adv_last, input ready);
  modport sink (input valid, input adv_dest, input adv_hop, input adv_cost,
                input adv_last, output ready);
endinterface

// ----- design/dvrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dvrt_ctrl
// Sequencer for route updates, table clear and the advertisement walk.
// ----------------------------------------------------------------------------
module dvrt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [dvrt_pkg::OP_W-1:0]  in_op,
  output logic                       in_ready,
  input  dvrt_pkg::ctrl_status_t     status,
  output dvrt_pkg::ctrl_cmd_t        cmd
);
  import dvrt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (in_op == OP_RECEIVE) begin
            state_next = ST_RECV;
          end else if (in_op == OP_ADVERTISE) begin
            cmd.idx_clear = 1'b1;
            state_next    = ST_SCAN;
          end else if (in_op == OP_CLEAR) begin
            cmd.clear_valid = 1'b1;
            state_next      = ST_INIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_RECV: begin
        cmd.recv_eval = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_SCAN: begin
        priority if (status.scan_valid) begin
          cmd.scan_rd = 1'b1;
          state_next  = ST_LOAD;
        end else if (status.scan_end) begin
          state_next = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_LOAD: begin
        // wait for the output register to drain
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.scan_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_SCAN;
          end
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// ----- design/dvrt_datapath.sv -----
// ----------------------------------------------------------------------------
// dvrt_datapath
// Route table storage, update compare, scan index and output register.
// ----------------------------------------------------------------------------
module dvrt_datapath #(
  parameter int NODES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [dvrt_pkg::NODE_W-1:0] cfg_wr_data,
  input  logic [dvrt_pkg::NODE_W-1:0] in_dest,
  input  logic [dvrt_pkg::NODE_W-1:0] in_hop,
  input  logic [dvrt_pkg::COST_W-1:0] in_cost,
  input  dvrt_pkg::ctrl_cmd_t         cmd,
  output dvrt_pkg::ctrl_status_t      status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dvrt_pkg::NODE_W-1:0] out_dest,
  output logic [dvrt_pkg::NODE_W-1:0] out_hop,
  output logic [dvrt_pkg::COST_W-1:0] out_cost,
  output logic                        out_last
);
  import dvrt_pkg::*;

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [6:0] NODES_V = 7'(NODES);
  localparam logic [IW-1:0] IDX_END = IW'(NODES - 1);

  typedef struct packed {
    logic [NODE_W-1:0] hop;
    logic [COST_W-1:0] distance;
  } entry_t;

  entry_t            table_mem [NODES];
  logic [NODES-1:0]  valid;
  logic [NODE_W-1:0] own_node;
  logic [NODE_W-1:0] item_dest;
  logic [NODE_W-1:0] item_hop;
  logic [COST_W-1:0] item_cost;
  logic [IW-1:0]     idx;
  entry_t            rd_data;

  logic              own_ok;
  logic              item_ok;
  logic [IW-1:0]     own_idx;
  logic [IW-1:0]     item_idx;
  logic [IW-1:0]     in_idx;
  logic              take;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic [NODES-1:0]  above;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node <= NODE_W'(1);
    end else if (cfg_wr_en) begin
      own_node <= cfg_wr_data;
    end
  end

  assign own_idx  = IW'(own_node - NODE_W'(1));
  assign item_idx = IW'(item_dest - NODE_W'(1));
  assign in_idx   = IW'(in_dest - NODE_W'(1));
  assign own_ok   = (own_node != '0) && ({3'b000, own_node} <= NODES_V);
  assign item_ok  = (item_dest != '0) && ({3'b000, item_dest} <= NODES_V);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_dest <= in_dest;
      item_hop  <= in_hop;
      item_cost <= in_cost;
    end
  end

  // empty entry is filled, own entry is kept, same hop refreshes, else shorter wins
  assign take = item_ok && (!valid[item_idx] ||
                ((item_dest != own_node) &&
                 ((rd_data.hop == item_hop) || (item_cost < rd_data.distance))));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item_idx;
    wr_data = '{hop: item_hop, distance: item_cost};
    if (cmd.init_wr) begin
      wr_en   = own_ok;
      wr_addr = own_idx;
      wr_data = '{hop: own_node, distance: '0};
    end else if (cmd.recv_eval) begin
      wr_en = take;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_data <= table_mem[idx];
    end else if (cmd.accept) begin
      rd_data <= table_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_valid) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  assign above = (valid >> idx) >> 1;

  assign status.scan_valid = valid[idx];
  assign status.scan_end   = (idx == IDX_END);
  assign status.scan_last  = (above == '0);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_dest <= NODE_W'(idx) + NODE_W'(1);
      out_hop  <= own_node;
      out_cost <= (rd_data.distance == COST_MAX) ? COST_MAX : rd_data.distance + COST_W'(1);
      out_last <= status.scan_last;
    end
  end

endmodule

// ----- design/distance_vector_route_table_top.sv -----
// ----------------------------------------------------------------------------
// distance_vector_route_table_top
// Distance-vector route table with one entry per destination node.
// ----------------------------------------------------------------------------
// Requests arrive on the route channel (valid/ready): operation 0 offers one
// advertised route, 1 walks the table and sends every valid entry on the
// advert channel, 2 empties the table and reinstalls the own entry, 3 is
// accepted and dropped. own_node must be written through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce it. The own
// entry is installed at the next clear; route updates and advertisements use it
// at once. A route update reads the entry from the table memory in the accept
// cycle and writes it back in the next. A clear empties the table in the
// accept cycle and reinstalls the own entry in the next. An advertisement
// steps the scan index past empty entries and reads each valid entry through
// the single table read port before loading it; the walk stops after the last
// valid entry, or covers the whole table when it is empty, and adv_last marks
// the final one. Results sit in an output register: while the receiver stalls
// the walk waits on it, and after the final entry is loaded a new request is
// taken. After reset ST_INIT installs the own entry before any request is taken.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top #(
  parameter int NODES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [dvrt_pkg::NODE_W-1:0] cfg_wr_data,
  dvrt_route_if.sink                  route,
  dvrt_adv_if.source                  advert
);
  import dvrt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  dvrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (route.valid),
    .in_op    (route.operation),
    .in_ready (route.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dvrt_datapath #(
    .NODES (NODES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_dest     (route.route_dest),
    .in_hop      (route.route_hop),
    .in_cost     (route.route_cost),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (advert.valid),
    .out_ready   (advert.ready),
    .out_dest    (advert.adv_dest),
    .out_hop     (advert.adv_hop),
    .out_cost    (advert.adv_cost),
    .out_last    (advert.adv_last)
  );

endmodule

// ----- design/dvrt_checker.sv -----
// ----------------------------------------------------------------------------
// dvrt_checker
// Port-level checks of the route table, bound to the top level.
// ----------------------------------------------------------------------------
module dvrt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [dvrt_pkg::OP_W-1:0]   in_op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dvrt_pkg::NODE_W-1:0] out_dest,
  input logic [dvrt_pkg::COST_W-1:0] out_cost,
  input logic                        out_last
);
  import dvrt_pkg::*;

  // every real operation drops ready in the cycle after it is accepted
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready &&
     (in_op == OP_RECEIVE || in_op == OP_ADVERTISE || in_op == OP_CLEAR))
    |=> !in_ready)
    else $error("request channel ready right after an operation");

  // advertised cost is stored distance plus one, saturating at COST_MAX, so never zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cost != '0))
    else $error("advertised cost of zero");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_dest != '0))
    else $error("advertised destination zero");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_dest) && $stable(out_cost) && $stable(out_last)))
    else $error("stalled advertisement changed");

endmodule

bind distance_vector_route_table_top dvrt_checker u_dvrt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (route.valid),
  .in_ready  (route.ready),
  .in_op     (route.operation),
  .out_valid (advert.valid),
  .out_ready (advert.ready),
  .out_dest  (advert.adv_dest),
  .out_cost  (advert.adv_cost),
  .out_last  (advert.adv_last)
);
